/* design/b64d_pkg.sv */
package b64d_pkg;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 16;
    localparam int TOTAL_W = 17;
    localparam int SEXT_W  = 6;

    // Largest value the limit register can hold, also its reset value
    localparam int unsigned CFG_MAX = 65535;

    // Default for the built-in output cap
    localparam int unsigned MAX_OUTPUT_DEF = 65535;

    // Pad character ends the message
    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

    // Sextet bit fields used when packing bytes
    localparam logic [SEXT_W-1:0] HI2_MASK = 6'h30;
    localparam logic [SEXT_W-1:0] LO4_MASK = 6'h0F;
    localparam logic [SEXT_W-1:0] MID4_MASK = 6'h3C;
    localparam logic [SEXT_W-1:0] LO2_MASK = 6'h03;

    // One result as it leaves the block
    typedef struct packed {
        logic [BYTE_W-1:0]  data_byte;
        logic               byte_valid;
        logic               done_res;
        logic               overflow;
        logic [TOTAL_W-1:0] total_bytes;
    } result_t;

    // Alphabet lookup: {hit, sextet}
    function automatic logic [SEXT_W:0] sextet_of(input logic [CHAR_W-1:0] c);
        logic [SEXT_W:0] r;
        r = '0;
        case (c) inside
            [8'h41:8'h5A]: r = {1'b1, 6'(c - 8'h41)};
            [8'h61:8'h7A]: r = {1'b1, 6'(c - 8'h61 + 8'd26)};
            [8'h30:8'h39]: r = {1'b1, 6'(c - 8'h30 + 8'd52)};
            8'h2B:         r = {1'b1, 6'd62};
            8'h2F:         r = {1'b1, 6'd63};
            default:       r = '0;
        endcase
        return r;
    endfunction

    // First byte of a group: all of s0, top two bits of s1
    function automatic logic [BYTE_W-1:0] pack_a(input logic [SEXT_W-1:0] s0,
                                                 input logic [SEXT_W-1:0] s1);
        logic [SEXT_W-1:0] t;
        t = s1 & HI2_MASK;
        return {s0, t[5:4]};
    endfunction

    // Second byte: low four bits of s1, upper four of s2
    function automatic logic [BYTE_W-1:0] pack_b(input logic [SEXT_W-1:0] s1,
                                                 input logic [SEXT_W-1:0] s2);
        logic [SEXT_W-1:0] t1;
        logic [SEXT_W-1:0] t2;
        t1 = s1 & LO4_MASK;
        t2 = s2 & MID4_MASK;
        return {t1[3:0], t2[5:2]};
    endfunction

    // Third byte: low two bits of s2, all of s3
    function automatic logic [BYTE_W-1:0] pack_c(input logic [SEXT_W-1:0] s2,
                                                 input logic [SEXT_W-1:0] s3);
        logic [SEXT_W-1:0] t;
        t = s2 & LO2_MASK;
        return {t[1:0], s3};
    endfunction

endpackage

/* design/base64_stream_decoder.sv */
// Streaming Base64 decoder, standard alphabet.
// Input channel: one character per item (char_code, end_of_text), taken at a
// clock edge with in_valid high and in_stall low. Characters outside the
// alphabet are skipped. Every fourth sextet yields three bytes. A pad or the
// marked last character flushes a partial group and gives a done result with
// the byte total; reaching the byte limit gives a done result with overflow.
// Output channel: one result per item on out_valid/out_stall; a byte result
// has byte_valid set, the closing result has done_res set.
// Configuration: cfg_we writes max_output_bytes; write only while idle. The
// limit in force is the smaller of that register and MAX_OUTPUT.
// An accepted item waits in the input register until the result buffer is
// free; it is then decoded and its results are registered into the buffer.
// Throughput: one item per cycle while the receiver does not stall and each
// item gives at most one result; an item with more results holds the decode
// stage while the output port moves them, one per cycle (at most four per item).
// Reset clears the input register, the result buffer and the message state,
// and loads the limit register with 65535. When the receiver stalls, the
// current result holds; the input register then fills, after which in_stall
// rises.
module base64_stream_decoder #(
    parameter int unsigned MAX_OUTPUT = b64d_pkg::MAX_OUTPUT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [b64d_pkg::CFG_W-1:0]    max_output_bytes,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [b64d_pkg::CHAR_W-1:0]   char_code,
    input  logic                          end_of_text,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [b64d_pkg::BYTE_W-1:0]   data_byte,
    output logic                          byte_valid,
    output logic                          done_res,
    output logic                          overflow,
    output logic [b64d_pkg::TOTAL_W-1:0]  total_bytes
);
    import b64d_pkg::*;

    // Built-in cap folded into the width of the limit register
    localparam int unsigned CAP_INT = (MAX_OUTPUT < CFG_MAX) ? MAX_OUTPUT : CFG_MAX;
    localparam logic [CFG_W-1:0] LIMIT_CAP = CFG_W'(CAP_INT);

    // Registers
    logic [CFG_W-1:0]   limit_reg;
    logic               in_full_reg, in_full_next;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic [SEXT_W-1:0]  st_reg [3];
    logic [SEXT_W-1:0]  st_next [3];
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               skip_reg, skip_next;
    logic [2:0]         grp_n_reg, grp_n_next;
    logic [1:0]         grp_idx_reg, grp_idx_next;
    result_t            grp_res_reg [4];

    // Decode working values
    logic [CFG_W-1:0]   limit;
    logic [SEXT_W:0]    lookup;
    logic [1:0]         cnt_w;
    logic [SEXT_W-1:0]  st_w [3];
    logic [TOTAL_W-1:0] tot_w;
    logic [BYTE_W-1:0]  bytes_w [3];
    logic [1:0]         nb;
    logic               has_done;
    logic               ovf_w;
    logic [2:0]         res_n;
    result_t            res_w [4];

    // Handshake
    logic               out_take;
    logic               grp_last;
    logic               grp_free;
    logic               advance;
    logic               in_take;

    assign out_valid = (grp_n_reg != 3'd0);
    assign out_take  = out_valid && !out_stall;
    assign grp_last  = ({1'b0, grp_idx_reg} + 3'd1 == grp_n_reg);
    assign grp_free  = !out_valid || (out_take && grp_last);
    assign advance   = in_full_reg && grp_free;
    assign in_stall  = in_full_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    assign limit  = (limit_reg < LIMIT_CAP) ? limit_reg : LIMIT_CAP;
    assign lookup = sextet_of(char_reg);

    // Decode one character against the message state
    always_comb
    begin
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        total_next = total_reg;
        skip_next  = skip_reg;
        cnt_w      = cnt_reg;
        st_w       = st_reg;
        tot_w      = total_reg;
        bytes_w    = '{default: '0};
        nb         = 2'd0;
        has_done   = 1'b0;
        ovf_w      = 1'b0;
        if (advance)
        begin
            if (skip_reg)
            begin
                // drop characters until the last one
                if (last_reg)
                begin
                    cnt_next   = 2'd0;
                    total_next = '0;
                    skip_next  = 1'b0;
                end
            end
            else if (char_reg == PAD_CHAR)
            begin
                // flush the partial group and close
                if (cnt_reg >= 2'd2)
                begin
                    bytes_w[0] = pack_a(st_reg[0], st_reg[1]);
                    nb = 2'd1;
                end
                if (cnt_reg == 2'd3)
                begin
                    bytes_w[1] = pack_b(st_reg[1], st_reg[2]);
                    nb = 2'd2;
                end
                tot_w      = total_reg + TOTAL_W'(nb);
                has_done   = 1'b1;
                cnt_next   = 2'd0;
                total_next = '0;
                skip_next  = !last_reg;
            end
            else if (total_reg >= {1'b0, limit})
            begin
                // limit reached: abort the message
                has_done   = 1'b1;
                ovf_w      = 1'b1;
                cnt_next   = 2'd0;
                total_next = '0;
                skip_next  = !last_reg;
            end
            else
            begin
                // gather a sextet, emit three bytes on the fourth
                if (lookup[SEXT_W])
                begin
                    if (cnt_reg != 2'd3)
                    begin
                        st_w[cnt_reg] = lookup[SEXT_W-1:0];
                        cnt_w = cnt_reg + 2'd1;
                    end
                    else
                    begin
                        bytes_w[0] = pack_a(st_reg[0], st_reg[1]);
                        bytes_w[1] = pack_b(st_reg[1], st_reg[2]);
                        bytes_w[2] = pack_c(st_reg[2], lookup[SEXT_W-1:0]);
                        nb    = 2'd3;
                        cnt_w = 2'd0;
                        tot_w = total_reg + TOTAL_W'(3);
                    end
                end
                if (last_reg)
                begin
                    // last character: flush what the group holds now
                    if (cnt_w >= 2'd2)
                    begin
                        bytes_w[0] = pack_a(st_w[0], st_w[1]);
                        nb = 2'd1;
                    end
                    if (cnt_w == 2'd3)
                    begin
                        bytes_w[1] = pack_b(st_w[1], st_w[2]);
                        nb = 2'd2;
                    end
                    if (cnt_w >= 2'd2)
                        tot_w = total_reg + TOTAL_W'(nb);
                    has_done   = 1'b1;
                    cnt_next   = 2'd0;
                    total_next = '0;
                    skip_next  = 1'b0;
                end
                else
                begin
                    cnt_next   = cnt_w;
                    st_next    = st_w;
                    total_next = tot_w;
                end
            end
        end
    end

    // Lay out the results of this item: bytes first, then done
    always_comb
    begin
        res_n = {1'b0, nb} + {2'b00, has_done};
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nb)
                res_w[i] = '{data_byte: bytes_w[i], byte_valid: 1'b1, done_res: 1'b0,
                             overflow: 1'b0, total_bytes: '0};
            else
                res_w[i] = '{data_byte: '0, byte_valid: 1'b0, done_res: 1'b1,
                             overflow: ovf_w, total_bytes: tot_w};
        end
        res_w[3] = '{data_byte: '0, byte_valid: 1'b0, done_res: 1'b1,
                     overflow: ovf_w, total_bytes: tot_w};
    end

    // Input register and result buffer control
    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_take)
            in_full_next = 1'b1;
        else if (advance)
            in_full_next = 1'b0;

        grp_n_next   = grp_n_reg;
        grp_idx_next = grp_idx_reg;
        if (advance && res_n != 3'd0)
        begin
            grp_n_next   = res_n;
            grp_idx_next = 2'd0;
        end
        else if (out_take)
        begin
            if (grp_last)
                grp_n_next = 3'd0;
            else
                grp_idx_next = grp_idx_reg + 2'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= CFG_W'(CFG_MAX);
            in_full_reg <= 1'b0;
            cnt_reg     <= 2'd0;
            total_reg   <= '0;
            skip_reg    <= 1'b0;
            grp_n_reg   <= 3'd0;
            grp_idx_reg <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= max_output_bytes;
            in_full_reg <= in_full_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            skip_reg    <= skip_next;
            grp_n_reg   <= grp_n_next;
            grp_idx_reg <= grp_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
            last_reg <= end_of_text;
        end
        st_reg <= st_next;
        if (advance && res_n != 3'd0)
            grp_res_reg <= res_w;
    end

    // Present the current result
    assign data_byte   = grp_res_reg[grp_idx_reg].data_byte;
    assign byte_valid  = grp_res_reg[grp_idx_reg].byte_valid;
    assign done_res    = grp_res_reg[grp_idx_reg].done_res;
    assign overflow    = grp_res_reg[grp_idx_reg].overflow;
    assign total_bytes = grp_res_reg[grp_idx_reg].total_bytes;

endmodule

/* design/b64d_checker.sv */
module b64d_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [b64d_pkg::BYTE_W-1:0]   data_byte,
    input logic                          byte_valid,
    input logic                          done_res,
    input logic                          overflow,
    input logic [b64d_pkg::TOTAL_W-1:0]  total_bytes
);
    import b64d_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_valid)
            && $stable(done_res) && $stable(overflow) && $stable(total_bytes))
        else $error("stalled result changed");

    // Each result is either a byte or the closing item, never both
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_valid != done_res))
        else $error("result is neither byte nor done, or both");

    // Byte results carry no total, and overflow only rides on done
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> total_bytes == '0 && !overflow)
        else $error("byte result carries done fields");

    // Nothing is offered in the first cycle after reset
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .done_res    (done_res),
    .overflow    (overflow),
    .total_bytes (total_bytes)
);

/* sim/testbench.sv */
module testbench;

    import b64d_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 200;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 32;
    localparam int DIRECTED_N    = 25;
    localparam int MAX_PRINTED   = 40;

    typedef enum logic {ROW_CHAR, ROW_LIMIT} row_kind_t;

    // One directed row: a character, or a write of the byte limit.
    // Where known_done is set, the closing result of the row is typed in.
    typedef struct {
        row_kind_t          kind;
        logic [CHAR_W-1:0]  ch;
        logic               last;
        logic [CFG_W-1:0]   limit;
        bit                 known_done;
        logic               ovf;
        logic [TOTAL_W-1:0] total;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{ROW_CHAR,  "T",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "W",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "F",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "u",   1'b1, 16'd0,     1'b1, 1'b0, 17'd3},
        // lone sextet as last character flushes nothing
        '{ROW_CHAR,  "A",   1'b1, 16'd0,     1'b1, 1'b0, 17'd0},
        '{ROW_CHAR,  "/",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "+",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  8'h00, 1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        // pad with two sextets: one byte, then skip to the last character
        '{ROW_CHAR,  "=",   1'b0, 16'd0,     1'b1, 1'b0, 17'd1},
        '{ROW_CHAR,  8'hFF, 1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "z",   1'b1, 16'd0,     1'b0, 1'b0, 17'd0},
        // invalid last character still closes the message
        '{ROW_CHAR,  "9",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  8'h80, 1'b1, 16'd0,     1'b1, 1'b0, 17'd0},
        // zero limit: any non-pad character overflows, pad does not
        '{ROW_LIMIT, 8'h00, 1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "a",   1'b0, 16'd0,     1'b1, 1'b1, 17'd0},
        '{ROW_CHAR,  "Z",   1'b1, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "=",   1'b1, 16'd0,     1'b1, 1'b0, 17'd0},
        // limit of three: one full group, then overflow
        '{ROW_LIMIT, 8'h00, 1'b0, 16'd3,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "0",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "0",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "0",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "0",   1'b0, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_CHAR,  "A",   1'b0, 16'd0,     1'b1, 1'b1, 17'd3},
        '{ROW_CHAR,  "B",   1'b1, 16'd0,     1'b0, 1'b0, 17'd0},
        '{ROW_LIMIT, 8'h00, 1'b0, 16'hFFFF,  1'b0, 1'b0, 17'd0}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   limit_data = '0;
    logic               in_valid = 1'b0;
    logic [CHAR_W-1:0]  char_code = '0;
    logic               end_of_text = 1'b0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic [BYTE_W-1:0]  data_byte;
    logic               byte_valid;
    logic               done_res;
    logic               overflow;
    logic [TOTAL_W-1:0] total_bytes;

    base64_stream_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .max_output_bytes (limit_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .char_code        (char_code),
        .end_of_text      (end_of_text),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .data_byte        (data_byte),
        .byte_valid       (byte_valid),
        .done_res         (done_res),
        .overflow         (overflow),
        .total_bytes      (total_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder shadow state
    logic [1:0]         sextets_held;
    logic [SEXT_W-1:0]  sextet_buf [3];
    logic [TOTAL_W-1:0] message_total;
    bit                 skipping;
    logic [CFG_W-1:0]   limit_reg;

    result_t decoded_queue [$];
    int      mismatch_count = 0;
    int      items_done = 0;
    bit      sender_burst = 1'b0;
    bit      long_hold_req = 1'b0;

    // Map a character to its sextet; hit is 0 outside the alphabet
    function automatic void char_to_sextet(input logic [CHAR_W-1:0] ch, output bit hit,
                                           output logic [SEXT_W-1:0] val);
        hit = 1'b1;
        val = '0;
        if (ch >= "A" && ch <= "Z")
            val = SEXT_W'(ch - "A");
        else if (ch >= "a" && ch <= "z")
            val = SEXT_W'(ch - "a" + 26);
        else if (ch >= "0" && ch <= "9")
            val = SEXT_W'(ch - "0" + 52);
        else if (ch == "+")
            val = 6'd62;
        else if (ch == "/")
            val = 6'd63;
        else
            hit = 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] sextet_to_char(input int idx);
        if (idx < 26)
            return CHAR_W'("A" + idx);
        else if (idx < 52)
            return CHAR_W'("a" + idx - 26);
        else if (idx < 62)
            return CHAR_W'("0" + idx - 52);
        else if (idx == 62)
            return "+";
        return "/";
    endfunction

    function automatic void emit_byte(input logic [BYTE_W-1:0] b);
        result_t r;
        r = '{data_byte: b, byte_valid: 1'b1, done_res: 1'b0, overflow: 1'b0,
              total_bytes: '0};
        decoded_queue.push_back(r);
        message_total = message_total + 1'b1;
    endfunction

    function automatic void emit_done(input logic ovf);
        result_t r;
        r = '{data_byte: '0, byte_valid: 1'b0, done_res: 1'b1, overflow: ovf,
              total_bytes: message_total};
        decoded_queue.push_back(r);
    endfunction

    function automatic void clear_message();
        sextets_held = '0;
        sextet_buf = '{default: '0};
        message_total = '0;
        skipping = 1'b0;
    endfunction

    // Flush a partial group: j sextets give j-1 bytes
    function automatic void flush_group();
        logic [SEXT_W-1:0] s1;
        logic [SEXT_W-1:0] s2;
        s1 = (sextets_held >= 2) ? sextet_buf[1] : '0;
        s2 = (sextets_held >= 3) ? sextet_buf[2] : '0;
        if (sextets_held >= 2)
            emit_byte({sextet_buf[0], s1[5:4]});
        if (sextets_held >= 3)
            emit_byte({s1[3:0], s2[5:2]});
    endfunction

    // Work out the results of one accepted character
    function automatic void decode_char(input logic [CHAR_W-1:0] ch, input logic last);
        int unsigned       eff_limit;
        bit                hit;
        logic [SEXT_W-1:0] s3;
        eff_limit = (limit_reg < MAX_OUTPUT_DEF) ? limit_reg : MAX_OUTPUT_DEF;
        if (skipping) begin
            if (last)
                clear_message();
            return;
        end
        if (ch == PAD_CHAR) begin
            flush_group();
            emit_done(1'b0);
            clear_message();
            skipping = !last;
            return;
        end
        if (message_total >= eff_limit) begin
            emit_done(1'b1);
            clear_message();
            skipping = !last;
            return;
        end
        char_to_sextet(ch, hit, s3);
        if (hit) begin
            if (sextets_held < 3) begin
                sextet_buf[sextets_held] = s3;
                sextets_held = sextets_held + 1'b1;
            end
            else begin
                emit_byte({sextet_buf[0], sextet_buf[1][5:4]});
                emit_byte({sextet_buf[1][3:0], sextet_buf[2][5:2]});
                emit_byte({sextet_buf[2][1:0], s3});
                sextets_held = '0;
            end
        end
        if (last) begin
            flush_group();
            emit_done(1'b0);
            clear_message();
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        if ($urandom_range(0, 9) == 0)
            return PAD_CHAR;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CFG_W-1:0] phase_limit(input int phase);
        case (phase)
            1: return 16'd0;
            2: return 16'd1;
            3: return 16'd2;
            4: return 16'd3;
            5, 6: return CFG_W'($urandom_range(4, 40));
            7: return CFG_W'($urandom_range(41, 65534));
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch %s: got %0d, expected %0d, at %0t", what, got, want, $time);
    endtask

    // Offer one item, hold it until taken, then predict its results
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last,
                             input bit known_done, input logic ovf,
                             input logic [TOTAL_W-1:0] total);
        int      gap;
        result_t r;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= ch;
        end_of_text <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (!skipping)
            items_done++;
        decode_char(ch, last);
        if (known_done) begin
            r = decoded_queue.pop_back();
            r = '{data_byte: '0, byte_valid: 1'b0, done_res: 1'b1, overflow: ovf,
                  total_bytes: total};
            decoded_queue.push_back(r);
        end
    endtask

    // Stop offering and wait out every pending result plus the pipeline
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (decoded_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        limit_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = value;
    endtask

    // Build one message: mostly well-formed groups, some noise and broken tails
    task automatic send_message(input int min_groups, input bit steady);
        logic [CHAR_W-1:0] msg [$];
        int                groups;
        int                ending;
        int                j;
        groups = min_groups + (($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                           : $urandom_range(4, 12));
        ending = $urandom_range(0, 99);
        sender_burst = steady || ($urandom_range(0, 3) == 0);
        for (int g = 0; g < groups; g++) begin
            for (int k = 0; k < 4; k++) begin
                if ($urandom_range(0, 99) < 6)
                    msg.push_back(noise_char());
                msg.push_back(sextet_to_char($urandom_range(0, 63)));
            end
        end
        if (ending < 45) begin
            // end on a data character, partial or full group
            j = $urandom_range(1, 4);
            repeat (j) msg.push_back(sextet_to_char($urandom_range(0, 63)));
        end
        else if (ending < 85) begin
            // pad ending, sometimes with trailing junk
            j = $urandom_range(0, 3);
            repeat (j) msg.push_back(sextet_to_char($urandom_range(0, 63)));
            msg.push_back(PAD_CHAR);
            if ($urandom_range(0, 1) == 1)
                msg.push_back(PAD_CHAR);
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) msg.push_back(noise_char());
        end
        else begin
            repeat ($urandom_range(1, 6)) msg.push_back(noise_char());
        end
        foreach (msg[i])
            send_char(msg[i], i == msg.size() - 1, 1'b0, 1'b0, '0);
    endtask

    // Receiver stall pattern, with an occasional long hold
    int stall_run = 0;
    bit stall_now = 1'b0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        int r;
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else begin
            if (stall_run == 0) begin
                stall_now = !stall_now;
                r = $urandom_range(0, 99);
                if (stall_now)
                    stall_run = (r < 85) ? $urandom_range(1, 3) : $urandom_range(4, 25);
                else
                    stall_run = (r < 70) ? $urandom_range(1, 10) : $urandom_range(20, 60);
            end
            stall_run--;
            out_stall <= stall_now;
        end
    end

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (decoded_queue.size() == 0) begin
                report_mismatch("result with nothing pending, total_bytes", total_bytes, 0);
            end
            else begin
                want = decoded_queue.pop_front();
                if (data_byte !== want.data_byte)
                    report_mismatch("data_byte", data_byte, want.data_byte);
                if (byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", byte_valid, want.byte_valid);
                if (done_res !== want.done_res)
                    report_mismatch("done_res", done_res, want.done_res);
                if (overflow !== want.overflow)
                    report_mismatch("overflow", overflow, want.overflow);
                if (total_bytes !== want.total_bytes)
                    report_mismatch("total_bytes", total_bytes, want.total_bytes);
            end
        end
    end

    // Abort when neither channel moves for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL base64_stream_decoder");
            $finish;
        end
    end

    initial
    begin
        int phase_goal;
        limit_reg = 16'hFFFF;
        clear_message();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIMIT)
                set_limit(directed_rows[i].limit);
            else
                send_char(directed_rows[i].ch, directed_rows[i].last,
                          directed_rows[i].known_done, directed_rows[i].ovf,
                          directed_rows[i].total);
        end

        // Random messages over a sweep of limits
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase != 0)
                set_limit(phase_limit(phase));
            phase_goal = items_done + PHASE_ITEMS;
            if (phase == 8) begin
                // hold the receiver while a long burst fills the block
                long_hold_req = 1'b1;
                send_message(20, 1'b1);
                wait_drained();
            end
            while (items_done < phase_goal)
                send_message(0, 1'b0);
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("PASS base64_stream_decoder");
        else
            $display("FAIL base64_stream_decoder");
        $finish;
    end

endmodule
